@@ src/lpr_pkg.sv @@
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared types and constants for the longest-prefix route lookup block.
// ----------------------------------------------------------------------------
package lpr_pkg;

  localparam int unsigned ROUTES     = 32;
  localparam int unsigned INTERFACES = 4;

  localparam int unsigned CntW  = $clog2(ROUTES + 1);
  localparam int unsigned AddrW = (ROUTES > 1) ? $clog2(ROUTES) : 1;

  localparam logic [5:0]  MaxLen  = 6'd32;
  localparam logic [7:0]  TtlMin  = 8'd2;
  localparam logic [31:0] AllOnes = 32'hFFFF_FFFF;

  typedef enum logic [0:0] {
    FuncAdd    = 1'b0,
    FuncLookup = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    StAdded     = 3'd0,
    StForwarded = 3'd1,
    StDropTtl   = 3'd2,
    StDropNoRte = 3'd3,
    StFull      = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    FsmIdle,
    FsmScan,
    FsmDrain,
    FsmFinal,
    FsmPush
  } fsm_e;

  typedef struct packed {
    logic        func;
    logic [31:0] route_prefix_in;
    logic [5:0]  prefix_len_in;
    logic        hop_present;
    logic [31:0] hop_address_in;
    logic [1:0]  iface_in;
    logic [31:0] dst_address;
    logic [7:0]  ttl_in;
  } lpr_req_t;

  typedef struct packed {
    status_e     status;
    logic [1:0]  out_iface;
    logic [31:0] next_hop_out;
    logic [7:0]  ttl_out;
  } lpr_rsp_t;

  // One stored route, one RAM word.
  typedef struct packed {
    logic [31:0] prefix;
    logic [5:0]  plen;
    logic        hop_flag;
    logic [31:0] hop_addr;
    logic [1:0]  iface;
  } route_entry_t;

  // Best match so far, handed from the match unit to the controller.
  typedef struct packed {
    logic        found;
    logic [5:0]  plen;
    logic        hop_flag;
    logic [31:0] hop_addr;
    logic [1:0]  iface;
  } best_t;

endpackage

@@ src/lpr_ram.sv @@
// ----------------------------------------------------------------------------
// lpr_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lpr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/lpr_match.sv @@
// ----------------------------------------------------------------------------
// lpr_match
// Compare one route word per cycle against the destination and keep the
// longest match; a later entry of equal length replaces the earlier one.
// ----------------------------------------------------------------------------
module lpr_match (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  clear_i,
  input  logic                  valid_i,
  input  lpr_pkg::route_entry_t entry_i,
  input  logic [31:0]           dst_i,
  output lpr_pkg::best_t        best_o
);
  import lpr_pkg::*;

  best_t       best_q, best_d;
  logic [31:0] mask;
  logic        hit;

  // Shift by 32 yields zero, so a full-length prefix gets an all-ones mask.
  assign mask = ~(AllOnes >> entry_i.plen);
  assign hit  = (((dst_i ^ entry_i.prefix) & mask) == '0) &&
                (entry_i.plen >= best_q.plen);

  always_comb begin
    best_d = best_q;
    if (clear_i) begin
      best_d = '0;
    end else if (valid_i && hit) begin
      best_d.found    = 1'b1;
      best_d.plen     = entry_i.plen;
      best_d.hop_flag = entry_i.hop_flag;
      best_d.hop_addr = entry_i.hop_addr;
      best_d.iface    = entry_i.iface;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= '0;
    end else begin
      best_q <= best_d;
    end
  end

  assign best_o = best_q;

endmodule

@@ src/longest_prefix_route_lookup.sv @@
// ----------------------------------------------------------------------------
// longest_prefix_route_lookup
// IPv4 forwarding table: add-route items append to a route RAM, lookup items
// scan it for the longest matching prefix and return interface and next hop.
// ----------------------------------------------------------------------------
// Order: an add, a refusal or an early drop passes from idle to push and then to
//   the output register; a lookup passes scan (one route RAM read per route),
//   drain, final and push. One item at a time: the next transfer is taken once
//   the result is in the output register, later under output stall.
// Reset: route count and control clear at once; the route RAM is not cleared,
//   since only entries below the route count are ever read.
module longest_prefix_route_lookup (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lpr_pkg::lpr_req_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lpr_pkg::lpr_rsp_t out_data_o
);
  import lpr_pkg::*;

  fsm_e              state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [AddrW-1:0]  raddr_q, raddr_d;
  logic [AddrW-1:0]  last_addr;
  logic              rd_vld_q;
  logic [31:0]       dst_q, dst_d;
  logic [7:0]        ttl_q, ttl_d;
  lpr_rsp_t          res_q, res_d;
  lpr_rsp_t          out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic              out_free;
  logic              table_full;
  logic              ram_we;
  logic              ram_re;
  route_entry_t      wentry;
  route_entry_t      rentry;
  logic              match_clear;
  best_t             best;

  assign out_free   = !out_valid_q || out_ready_i;
  assign table_full = (count_q == CntW'(ROUTES));
  assign last_addr  = AddrW'(count_q - CntW'(1));

  // Saturate the prefix length; a direct route stores a zero hop.
  always_comb begin
    wentry.prefix   = in_data_i.route_prefix_in;
    wentry.plen     = (in_data_i.prefix_len_in > MaxLen) ? MaxLen
                                                         : in_data_i.prefix_len_in;
    wentry.hop_flag = in_data_i.hop_present;
    wentry.hop_addr = in_data_i.hop_present ? in_data_i.hop_address_in : '0;
    wentry.iface    = in_data_i.iface_in;
  end

  // Writes happen only at an input transfer in idle, reads only in scan,
  // so the two never touch the same entry in the same cycle.
  lpr_ram #(
    .Width($bits(route_entry_t)),
    .Depth(ROUTES)
  ) u_route_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(count_q[AddrW-1:0]),
    .wdata_i(wentry),
    .re_i   (ram_re),
    .raddr_i(raddr_q),
    .rdata_o(rentry)
  );

  lpr_match u_match (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clear_i(match_clear),
    .valid_i(rd_vld_q),
    .entry_i(rentry),
    .dst_i  (dst_q),
    .best_o (best)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    raddr_d     = raddr_q;
    dst_d       = dst_q;
    ttl_d       = ttl_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    in_ready_o  = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    match_clear = 1'b0;

    // Drain the output register on transfer.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      FsmIdle: begin
        // Ready is high throughout idle, so valid alone marks a transfer.
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          res_d = '0;
          if (in_data_i.func == FuncAdd) begin
            if (table_full) begin
              res_d.status = StFull;
            end else begin
              res_d.status = StAdded;
              ram_we       = 1'b1;
              count_d      = count_q + CntW'(1);
            end
            state_d = FsmPush;
          end else if (in_data_i.ttl_in < TtlMin) begin
            res_d.status = StDropTtl;
            state_d      = FsmPush;
          end else if (count_q == '0) begin
            res_d.status = StDropNoRte;
            state_d      = FsmPush;
          end else begin
            dst_d       = in_data_i.dst_address;
            ttl_d       = in_data_i.ttl_in;
            raddr_d     = '0;
            match_clear = 1'b1;
            state_d     = FsmScan;
          end
        end
      end
      FsmScan: begin
        // Issue one read per cycle; data meets the match unit in the next cycle.
        ram_re = 1'b1;
        if (raddr_q == last_addr) begin
          state_d = FsmDrain;
        end else begin
          raddr_d = raddr_q + AddrW'(1);
        end
      end
      FsmDrain: begin
        // Last read word is compared at the end of this cycle.
        state_d = FsmFinal;
      end
      FsmFinal: begin
        res_d = '0;
        if (!best.found || (32'(best.iface) >= INTERFACES)) begin
          res_d.status = StDropNoRte;
        end else begin
          res_d.status       = StForwarded;
          res_d.out_iface    = best.iface;
          res_d.next_hop_out = best.hop_flag ? best.hop_addr : dst_q;
          res_d.ttl_out      = ttl_q - 8'd1;
        end
        state_d = FsmPush;
      end
      FsmPush: begin
        // Hold the result until the output register is free.
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = FsmIdle;
        end
      end
      default: begin
        state_d = FsmIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FsmIdle;
      count_q     <= '0;
      raddr_q     <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      raddr_q     <= raddr_d;
      rd_vld_q    <= ram_re;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dst_q <= dst_d;
    ttl_q <= ttl_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: longest-prefix route lookup testbench
// Drives add-route and lookup transfers through the valid/ready channels. A
// scoreboard keeps its own copy of the forwarding table and works out the
// status, interface, next hop and TTL of every accepted request. It then
// checks each returned transfer against the oldest outstanding verdict.
// ----------------------------------------------------------------------------
module tb;
  import lpr_pkg::*;

  // Random part of the stimulus, after the directed opening.
  localparam int RandomItems = 1630;
  // Last stretch of the run, with no idling on either side.
  localparam int CalmItems = 150;

  // --------------------------------------------------------------------------
  // Scoreboard: private forwarding table plus a queue of expected verdicts.
  // --------------------------------------------------------------------------
  class lpm_scoreboard;
    logic [31:0] pfx_tbl[ROUTES];
    logic [5:0]  len_tbl[ROUTES];
    logic        via_tbl[ROUTES];
    logic [31:0] gw_tbl[ROUTES];
    logic [1:0]  port_tbl[ROUTES];
    int unsigned n_routes;
    lpr_rsp_t    verdict_q[$];
    int unsigned mismatches;
    int unsigned checked;

    function new();
      n_routes   = 0;
      mismatches = 0;
      checked    = 0;
    endfunction

    // Apply one request to the table and return the verdict it earns.
    function lpr_rsp_t forward_decision(lpr_req_t req);
      lpr_rsp_t    rsp;
      logic [31:0] mask;
      logic [5:0]  best_len;
      int          best;
      rsp        = '0;
      rsp.status = StAdded;
      if (req.func == FuncAdd) begin
        if (n_routes >= ROUTES) begin
          rsp.status = StFull;
        end else begin
          pfx_tbl[AddrW'(n_routes)]  = req.route_prefix_in;
          len_tbl[AddrW'(n_routes)]  = (req.prefix_len_in > MaxLen) ? MaxLen
                                                                    : req.prefix_len_in;
          via_tbl[AddrW'(n_routes)]  = req.hop_present;
          gw_tbl[AddrW'(n_routes)]   = req.hop_present ? req.hop_address_in : '0;
          port_tbl[AddrW'(n_routes)] = req.iface_in;
          n_routes++;
        end
      end else if (req.ttl_in < TtlMin) begin
        rsp.status = StDropTtl;
      end else begin
        best     = -1;
        best_len = '0;
        // Scan every stored route; ">=" lets a later route win a tie.
        for (int i = 0; i < n_routes; i++) begin
          mask = (len_tbl[AddrW'(i)] == 0) ? '0 : (AllOnes << (32 - len_tbl[AddrW'(i)]));
          if ((((req.dst_address ^ pfx_tbl[AddrW'(i)]) & mask) == '0) &&
              (len_tbl[AddrW'(i)] >= best_len)) begin
            best     = i;
            best_len = len_tbl[AddrW'(i)];
          end
        end
        if (best < 0 || port_tbl[AddrW'(best)] >= INTERFACES) begin
          rsp.status = StDropNoRte;
        end else begin
          rsp.status       = StForwarded;
          rsp.out_iface    = port_tbl[AddrW'(best)];
          rsp.next_hop_out = via_tbl[AddrW'(best)] ? gw_tbl[AddrW'(best)]
                                                   : req.dst_address;
          rsp.ttl_out      = req.ttl_in - 8'd1;
        end
      end
      return rsp;
    endfunction

    function void note_request(lpr_req_t req);
      verdict_q = {verdict_q, forward_decision(req)};
    endfunction

    function int outstanding();
      return verdict_q.size();
    endfunction

    task flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
      mismatches++;
    endtask

    task check_response(lpr_rsp_t got);
      lpr_rsp_t want;
      checked++;
      if (verdict_q.size() == 0) begin
        flag_mismatch("unexpected result, status", 32'(got.status), '0);
      end else begin
        want = verdict_q.pop_front();
        if (got.status !== want.status) begin
          flag_mismatch("status", 32'(got.status), 32'(want.status));
        end
        if (got.out_iface !== want.out_iface) begin
          flag_mismatch("out_iface", 32'(got.out_iface), 32'(want.out_iface));
        end
        if (got.next_hop_out !== want.next_hop_out) begin
          flag_mismatch("next_hop_out", got.next_hop_out, want.next_hop_out);
        end
        if (got.ttl_out !== want.ttl_out) begin
          flag_mismatch("ttl_out", 32'(got.ttl_out), 32'(want.ttl_out));
        end
      end
    endtask
  endclass

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  lpr_req_t in_data_i;
  logic     out_valid_o;
  logic     out_ready_i;
  lpr_rsp_t out_data_o;

  lpm_scoreboard sb = new();

  // Prefixes handed to the block so far; lookups aim near them to hit routes.
  logic [31:0] route_pool[$];
  // Set for the final stretch: no idling on either side from then on.
  bit calm;
  // Long receiver hold-off that backs the block up into its input.
  logic hold_off;

  longest_prefix_route_lookup uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hold reset low from the start, then release it for good.
  initial begin
    rst_ni <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Build an add-route request; fill the lookup fields with noise.
  function automatic lpr_req_t mk_add(logic [31:0] pfx, logic [5:0] plen, logic via,
                                      logic [31:0] gw, logic [1:0] port);
    lpr_req_t req;
    req.func            = FuncAdd;
    req.route_prefix_in = pfx;
    req.prefix_len_in   = plen;
    req.hop_present     = via;
    req.hop_address_in  = gw;
    req.iface_in        = port;
    req.dst_address     = $urandom;
    req.ttl_in          = 8'($urandom);
    route_pool = {route_pool, pfx};
    return req;
  endfunction

  // Build a lookup request; fill the add fields with noise.
  function automatic lpr_req_t mk_lookup(logic [31:0] dst, logic [7:0] ttl);
    lpr_req_t req;
    req.func            = FuncLookup;
    req.route_prefix_in = $urandom;
    req.prefix_len_in   = 6'($urandom);
    req.hop_present     = 1'($urandom);
    req.hop_address_in  = $urandom;
    req.iface_in        = 2'($urandom);
    req.dst_address     = dst;
    req.ttl_in          = ttl;
    return req;
  endfunction

  function automatic lpr_req_t random_item();
    int          add_pct;
    int          k;
    logic [31:0] flip;
    logic [31:0] dst;
    logic [7:0]  ttl;
    logic [5:0]  plen;
    // Adds are frequent until the table fills, then only probe the full case.
    add_pct = (route_pool.size() < ROUTES) ? 35 : 6;
    if ($urandom_range(0, 99) < add_pct) begin
      plen = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                         : 6'($urandom_range(0, 32));
      return mk_add($urandom, plen, 1'($urandom), $urandom, 2'($urandom));
    end
    // Mostly aim near a known prefix, flipping a random number of low bits.
    if (route_pool.size() != 0 && $urandom_range(0, 3) != 0) begin
      k    = $urandom_range(0, 32);
      flip = (k == 0) ? '0 : (AllOnes >> (32 - k));
      dst  = route_pool[$urandom_range(0, route_pool.size() - 1)] ^ ($urandom & flip);
    end else begin
      dst = $urandom;
    end
    case ($urandom_range(0, 9))
      0:       ttl = 8'($urandom_range(0, 1));
      1:       ttl = 8'd255;
      default: ttl = 8'($urandom_range(2, 255));
    endcase
    return mk_lookup(dst, ttl);
  endfunction

  // --------------------------------------------------------------------------
  // Request side: directed opening, then random traffic with idle bursts.
  // --------------------------------------------------------------------------
  initial begin : feed_requests
    lpr_req_t directed_q[$];
    lpr_req_t req;
    int       total;
    int       gap;
    int       idle_pct;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    calm     = 1'b0;
    idle_pct = 0;

    // Empty table: no route. TTL of 0 and 1: dropped before any lookup.
    directed_q = {directed_q, mk_lookup(32'h0A00_0001, 8'd64)};
    directed_q = {directed_q, mk_lookup(32'hC0A8_0101, 8'd0)};
    directed_q = {directed_q, mk_lookup(32'hC0A8_0101, 8'd1)};
    // Zero-length default route matches everything; direct, so hop is dst.
    directed_q = {directed_q, mk_add(32'hDEAD_BEEF, 6'd0, 1'b0, 32'h1234_5678, 2'd0)};
    directed_q = {directed_q, mk_lookup(32'hFFFF_FFFF, 8'd255)};
    directed_q = {directed_q, mk_lookup(32'h0000_0000, 8'd2)};
    // A /16 with a gateway, a host route given an oversized length, the same
    // /16 again (the later one must win the tie), an all-ones host route and
    // a length just above the maximum.
    directed_q = {directed_q, mk_add(32'hC0A8_0000, 6'd16, 1'b1, 32'h0A00_0001, 2'd1)};
    directed_q = {directed_q, mk_add(32'hC0A8_0100, 6'd63, 1'b1, 32'hFFFF_FFFF, 2'd3)};
    directed_q = {directed_q, mk_add(32'hC0A8_0000, 6'd16, 1'b0, 32'hFFFF_FFFF, 2'd2)};
    directed_q = {directed_q, mk_add(32'hFFFF_FFFF, 6'd32, 1'b1, 32'h0000_0000, 2'd2)};
    directed_q = {directed_q, mk_add(32'h0A0B_0C0D, 6'd33, 1'b1, 32'h5555_AAAA, 2'd3)};
    directed_q = {directed_q, mk_lookup(32'hC0A8_0100, 8'd100)};
    directed_q = {directed_q, mk_lookup(32'hC0A8_FF01, 8'd9)};
    directed_q = {directed_q, mk_lookup(32'hFFFF_FFFF, 8'd255)};
    directed_q = {directed_q, mk_lookup(32'hC0A8_0101, 8'd3)};
    directed_q = {directed_q, mk_lookup(32'h1234_5678, 8'd128)};
    directed_q = {directed_q, mk_lookup(32'h0A0B_0C0D, 8'd200)};
    directed_q = {directed_q, mk_lookup(32'h0A0B_0C0C, 8'd2)};

    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);

    total = directed_q.size() + RandomItems;
    for (int idx = 0; idx < total; idx++) begin
      // Change the idle density every hundred requests, zero included.
      if (idx % 100 == 0) begin
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 15;
          default: idle_pct = 40;
        endcase
      end
      if (idx >= total - CalmItems) calm = 1'b1;
      req = (idx < directed_q.size()) ? directed_q[idx] : random_item();
      gap = (!calm && $urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 8) : 0;
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      // Offer the request and hold it until the transfer happens.
      in_valid_i <= 1'b1;
      in_data_i  <= req;
      @(posedge clk_i);
      while (!in_ready_o) @(posedge clk_i);
      sb.note_request(req);
    end
    in_valid_i <= 1'b0;

    // Drain: wait for every verdict, then allow one full scan for strays.
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (ROUTES + 8) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: check each transfer, stall in random bursts.
  // --------------------------------------------------------------------------
  initial begin : drain_results
    int stall_left;
    int stall_pct;
    out_ready_i <= 1'b0;
    stall_left = 0;
    stall_pct  = 20;
    forever begin
      @(posedge clk_i);
      // Sample the values the block saw at this edge.
      if (out_valid_o && out_ready_i) sb.check_response(out_data_o);
      if ($urandom_range(0, 199) == 0) begin
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 10;
          default: stall_pct = 35;
        endcase
      end
      if (hold_off) begin
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, 7);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Once some traffic has gone through, block the result side for a long
  // stretch while requests keep coming, so the input backs up and stalls.
  initial begin : back_pressure
    hold_off <= 1'b0;
    while (sb.checked < 300) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // Watchdog: several times the slowest legal run.
  initial begin : watchdog
    #2_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
